/* design/cdpg_pkg.sv */
// Shared constants and types for the cube distance panning gain pipeline.
package cdpg_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned NCORNER = 8;
  localparam int unsigned NAXIS   = 3;

  // Q2.14 position limits and fade knee
  localparam logic signed [POS_W-1:0] POS_MAX   = 16'sd16384;
  localparam logic signed [POS_W-1:0] POS_MIN   = -16'sd16384;
  localparam logic signed [POS_W-1:0] EDGE_HI   = 16'sd13107;
  localparam logic signed [POS_W-1:0] EDGE_LO   = -16'sd13107;
  localparam logic        [POS_W-1:0] POS_ONE_U = 16'd16384;

  // Fade factor, Q.16
  localparam int unsigned FADE_W = 17;
  localparam logic [FADE_W-1:0] FADE_UNIT  = 17'd65536;
  localparam logic [FADE_W-1:0] FADE_SLOPE = 17'd20;

  // Square root unit: 64-bit radicand, 32-bit root, one root bit per stage
  localparam int unsigned RIN_W      = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SREM_W     = ROOT_W + 4;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  // Distance and reciprocal
  localparam int unsigned DIST_W     = 16;
  localparam logic [DIST_W-1:0] DIST_FLOOR = 16'd16;
  localparam int unsigned DEN_W      = 34;
  localparam logic [DEN_W-1:0]  DEN_ONE    = 34'h0_1000_0000;
  localparam int unsigned RGAIN_W    = 30;
  localparam int unsigned RREM_W     = DEN_W + 1;
  localparam int unsigned RECIP_STEPS = RGAIN_W;

  // Normalizing divider: quotient up to 2^16
  localparam int unsigned NQ_W       = GAIN_W + 1;
  localparam int unsigned NDIV_STEPS = NQ_W;

  // Speaker side per axis, bit set means +1; bit 0 x, bit 1 y, bit 2 z
  localparam logic [NAXIS-1:0] CORNER_POS [NCORNER] = '{
    3'b100, 3'b101, 3'b000, 3'b001, 3'b110, 3'b111, 3'b010, 3'b011
  };

  // Fade set travels alongside the distance path
  localparam int unsigned FADE_DLY = SQRT_STEPS + RECIP_STEPS + 3;

  // Input transfer edge to output transfer edge
  localparam int unsigned OUT_LATENCY = 2 * SQRT_STEPS + RECIP_STEPS + NDIV_STEPS + 13;

  typedef logic [FADE_W-1:0] fade_t;

  typedef struct packed {
    logic [NAXIS-1:0][FADE_W-1:0] lo;  // for speakers on the +1 side
    logic [NAXIS-1:0][FADE_W-1:0] hi;  // for speakers on the -1 side
  } fade_set_t;

endpackage

/* design/cdpg_sqrt.sv */
// Pipelined integer floor square root, one root bit per stage.
module cdpg_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic [cdpg_pkg::RIN_W-1:0]  in_val,
  output logic                        out_vld,
  output logic [cdpg_pkg::ROOT_W-1:0] out_root
);

  logic [cdpg_pkg::SQRT_STEPS-1:0] vld;
  logic [cdpg_pkg::RIN_W-1:0]      val  [cdpg_pkg::SQRT_STEPS];
  logic [cdpg_pkg::SREM_W-1:0]     rem  [cdpg_pkg::SQRT_STEPS];
  logic [cdpg_pkg::ROOT_W-1:0]     root [cdpg_pkg::SQRT_STEPS];

  for (genvar k = 0; k < cdpg_pkg::SQRT_STEPS; k++) begin : g_step
    logic                        vld_in;
    logic [cdpg_pkg::RIN_W-1:0]  val_in;
    logic [cdpg_pkg::SREM_W-1:0] rem_in;
    logic [cdpg_pkg::ROOT_W-1:0] root_in;
    logic [cdpg_pkg::SREM_W-1:0] rem_sh;
    logic [cdpg_pkg::SREM_W-1:0] trial;
    logic                        ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign val_in  = in_val;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld[k-1];
      assign val_in  = val[k-1];
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[cdpg_pkg::SREM_W-3:0], val_in[cdpg_pkg::RIN_W-1-2*k -: 2]};
      trial  = {2'b00, root_in, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      val[k]  <= val_in;
      rem[k]  <= ge ? rem_sh - trial : rem_sh;
      root[k] <= {root_in[cdpg_pkg::ROOT_W-2:0], ge};
    end
  end

  assign out_vld  = vld[cdpg_pkg::SQRT_STEPS-1];
  assign out_root = root[cdpg_pkg::SQRT_STEPS-1];

endmodule

/* design/cdpg_recip.sv */
// Pipelined raw gain 2^58 / den, one quotient bit per stage.
module cdpg_recip (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic [cdpg_pkg::DEN_W-1:0]   in_den,
  output logic                         out_vld,
  output logic [cdpg_pkg::RGAIN_W-1:0] out_quo
);

  logic [cdpg_pkg::RECIP_STEPS-1:0] vld;
  logic [cdpg_pkg::DEN_W-1:0]       den [cdpg_pkg::RECIP_STEPS];
  logic [cdpg_pkg::RREM_W-1:0]      rem [cdpg_pkg::RECIP_STEPS];
  logic [cdpg_pkg::RGAIN_W-1:0]     quo [cdpg_pkg::RECIP_STEPS];

  for (genvar k = 0; k < cdpg_pkg::RECIP_STEPS; k++) begin : g_step
    logic                         vld_in;
    logic [cdpg_pkg::DEN_W-1:0]   den_in;
    logic [cdpg_pkg::RREM_W-1:0]  rem_in;
    logic [cdpg_pkg::RGAIN_W-1:0] quo_in;
    logic [cdpg_pkg::RREM_W-1:0]  rem_sh;
    logic [cdpg_pkg::RREM_W-1:0]  dvs;
    logic                         ge;

    if (k == 0) begin : g_first
      // numerator bits above the quotient leave 2^28 as the start remainder
      assign vld_in = in_vld;
      assign den_in = in_den;
      assign rem_in = cdpg_pkg::RREM_W'(cdpg_pkg::DEN_ONE);
      assign quo_in = '0;
    end else begin : g_next
      assign vld_in = vld[k-1];
      assign den_in = den[k-1];
      assign rem_in = rem[k-1];
      assign quo_in = quo[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[cdpg_pkg::RREM_W-2:0], 1'b0};
      dvs    = {1'b0, den_in};
      ge     = rem_sh >= dvs;
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      den[k] <= den_in;
      rem[k] <= ge ? rem_sh - dvs : rem_sh;
      quo[k] <= {quo_in[cdpg_pkg::RGAIN_W-2:0], ge};
    end
  end

  assign out_vld = vld[cdpg_pkg::RECIP_STEPS-1];
  assign out_quo = quo[cdpg_pkg::RECIP_STEPS-1];

endmodule

/* design/cdpg_ndiv.sv */
// Pipelined normalizing divide (gain << 16) / root with saturation.
module cdpg_ndiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic [cdpg_pkg::RGAIN_W-1:0] in_gain,
  input  logic [cdpg_pkg::ROOT_W-1:0]  in_root,
  output logic                         out_vld,
  output logic [cdpg_pkg::GAIN_W-1:0]  out_gain
);

  logic [cdpg_pkg::NDIV_STEPS-1:0] vld;
  logic [cdpg_pkg::ROOT_W-1:0]     root [cdpg_pkg::NDIV_STEPS];
  logic [cdpg_pkg::ROOT_W-1:0]     rem  [cdpg_pkg::NDIV_STEPS];
  logic [cdpg_pkg::NQ_W-1:0]       quo  [cdpg_pkg::NDIV_STEPS];
  logic                            zero [cdpg_pkg::NDIV_STEPS];
  logic [cdpg_pkg::GAIN_W-1:0]     alt  [cdpg_pkg::NDIV_STEPS];

  for (genvar k = 0; k < cdpg_pkg::NDIV_STEPS; k++) begin : g_step
    logic                        vld_in;
    logic [cdpg_pkg::ROOT_W-1:0] root_in;
    logic [cdpg_pkg::ROOT_W-1:0] rem_in;
    logic [cdpg_pkg::NQ_W-1:0]   quo_in;
    logic                        zero_in;
    logic [cdpg_pkg::GAIN_W-1:0] alt_in;
    logic                        bit_in;
    logic [cdpg_pkg::ROOT_W:0]   rem_sh;
    logic [cdpg_pkg::ROOT_W:0]   diff;
    logic                        ge;

    if (k == 0) begin : g_first
      // quotient stays below 2^17, so the top numerator bits fold into the start remainder
      assign vld_in  = in_vld;
      assign root_in = in_root;
      assign rem_in  = cdpg_pkg::ROOT_W'(in_gain[cdpg_pkg::RGAIN_W-1:1]);
      assign quo_in  = '0;
      assign zero_in = in_root == '0;
      assign alt_in  = in_gain[cdpg_pkg::RGAIN_W-1 -: cdpg_pkg::GAIN_W];
      assign bit_in  = in_gain[0];
    end else begin : g_next
      assign vld_in  = vld[k-1];
      assign root_in = root[k-1];
      assign rem_in  = rem[k-1];
      assign quo_in  = quo[k-1];
      assign zero_in = zero[k-1];
      assign alt_in  = alt[k-1];
      assign bit_in  = 1'b0;
    end

    always_comb begin
      rem_sh = {rem_in, bit_in};
      diff   = rem_sh - {1'b0, root_in};
      ge     = rem_sh >= {1'b0, root_in};
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      root[k] <= root_in;
      rem[k]  <= ge ? diff[cdpg_pkg::ROOT_W-1:0] : rem_sh[cdpg_pkg::ROOT_W-1:0];
      quo[k]  <= {quo_in[cdpg_pkg::NQ_W-2:0], ge};
      zero[k] <= zero_in;
      alt[k]  <= alt_in;
    end
  end

  localparam int unsigned LAST = cdpg_pkg::NDIV_STEPS - 1;

  assign out_vld = vld[LAST];

  always_comb begin
    if (zero[LAST])                     out_gain = alt[LAST];
    else if (quo[LAST][cdpg_pkg::NQ_W-1]) out_gain = '1;
    else                                out_gain = quo[LAST][cdpg_pkg::GAIN_W-1:0];
  end

endmodule

/* design/cube_distance_panning_gains.sv */
// Top level: eight-speaker cube panner gain pipeline.
//
// Usage
//   One source position (pos_x, pos_y, pos_z, signed Q2.14) transfers in at a rising
//   edge where start is high and busy is low. busy is high only during reset, so a
//   new position can be issued every clock cycle.
//   Eight speaker gains (gain_0..gain_7, Q0.16) appear together for one cycle with
//   done high; that cycle's closing edge is the output transfer. The receiver cannot
//   stall, so nothing is held back and nothing waits.
// Pipeline and throughput
//   From the input transfer to the output transfer an item passes through:
//   3 front stages, 32 root stages for distance, 2 stages for the denominator,
//   30 reciprocal stages, 3 fade stages, 4 stages for the sum of squares, 32 root
//   stages for the norm, 17 normalizing-divide stages and the output register.
//   The bit-serial root and divide stages set that depth; throughput is one
//   position per cycle outside reset.
// Reset
//   rst (synchronous) clears every valid bit, so items in flight are dropped and
//   done stays low until a position transferred after reset emerges.
module cube_distance_panning_gains (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [cdpg_pkg::POS_W-1:0] pos_x,
  input  logic signed [cdpg_pkg::POS_W-1:0] pos_y,
  input  logic signed [cdpg_pkg::POS_W-1:0] pos_z,
  output logic                             done,
  output logic [cdpg_pkg::GAIN_W-1:0]       gain_0,
  output logic [cdpg_pkg::GAIN_W-1:0]       gain_1,
  output logic [cdpg_pkg::GAIN_W-1:0]       gain_2,
  output logic [cdpg_pkg::GAIN_W-1:0]       gain_3,
  output logic [cdpg_pkg::GAIN_W-1:0]       gain_4,
  output logic [cdpg_pkg::GAIN_W-1:0]       gain_5,
  output logic [cdpg_pkg::GAIN_W-1:0]       gain_6,
  output logic [cdpg_pkg::GAIN_W-1:0]       gain_7
);

  // clamp to [-1, +1]
  function automatic logic signed [cdpg_pkg::POS_W-1:0] sat_pos(
    input logic signed [cdpg_pkg::POS_W-1:0] v
  );
    if (v > cdpg_pkg::POS_MAX)      return cdpg_pkg::POS_MAX;
    else if (v < cdpg_pkg::POS_MIN) return cdpg_pkg::POS_MIN;
    else                            return v;
  endfunction

  // pick the fade that applies to one speaker on one axis
  function automatic cdpg_pkg::fade_t fade_pick(
    input cdpg_pkg::fade_set_t fs,
    input logic [2:0]          corner,
    input logic [1:0]          axis
  );
    return cdpg_pkg::CORNER_POS[corner][axis] ? fs.lo[axis] : fs.hi[axis];
  endfunction

  // gain * fade / 2^16, floor; fade never exceeds unity
  function automatic logic [cdpg_pkg::RGAIN_W-1:0] fade_mul(
    input logic [cdpg_pkg::RGAIN_W-1:0] g,
    input cdpg_pkg::fade_t              f
  );
    logic [cdpg_pkg::RGAIN_W+cdpg_pkg::FADE_W-1:0] p;
    p = (cdpg_pkg::RGAIN_W+cdpg_pkg::FADE_W)'(g) * (cdpg_pkg::RGAIN_W+cdpg_pkg::FADE_W)'(f);
    return p[cdpg_pkg::RGAIN_W+15:16];
  endfunction

  assign busy = rst;

  logic signed [cdpg_pkg::POS_W-1:0] pos_in [cdpg_pkg::NAXIS];
  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;

  // ---------------- front: clamp, per-axis distances, fades ----------------
  logic                              a_vld;
  logic signed [cdpg_pkg::POS_W-1:0] a_pos [cdpg_pkg::NAXIS];

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= start;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < cdpg_pkg::NAXIS; a++) a_pos[a] <= sat_pos(pos_in[a]);
  end

  // |speaker - source| per axis: 16384 +/- s, never above 32768
  logic [cdpg_pkg::POS_W-1:0] u_lo [cdpg_pkg::NAXIS];
  logic [cdpg_pkg::POS_W-1:0] u_hi [cdpg_pkg::NAXIS];
  cdpg_pkg::fade_set_t        fade_now;

  for (genvar a = 0; a < cdpg_pkg::NAXIS; a++) begin : g_axis
    logic [cdpg_pkg::FADE_W-1:0] p_lo;
    logic [cdpg_pkg::FADE_W-1:0] p_hi;
    always_comb begin
      u_lo[a] = $unsigned(a_pos[a]) + cdpg_pkg::POS_ONE_U;
      u_hi[a] = cdpg_pkg::POS_ONE_U - $unsigned(a_pos[a]);
      // only used near a face, where the offset fits in 12 bits
      p_lo = cdpg_pkg::FADE_W'(u_lo[a][11:0]) * cdpg_pkg::FADE_SLOPE;
      p_hi = cdpg_pkg::FADE_W'(u_hi[a][11:0]) * cdpg_pkg::FADE_SLOPE;
      if (a_pos[a] <= cdpg_pkg::EDGE_LO)
        fade_now.lo[a] = (p_lo > cdpg_pkg::FADE_UNIT) ? cdpg_pkg::FADE_UNIT : p_lo;
      else
        fade_now.lo[a] = cdpg_pkg::FADE_UNIT;
      if (a_pos[a] >= cdpg_pkg::EDGE_HI)
        fade_now.hi[a] = (p_hi > cdpg_pkg::FADE_UNIT) ? cdpg_pkg::FADE_UNIT : p_hi;
      else
        fade_now.hi[a] = cdpg_pkg::FADE_UNIT;
    end
  end

  logic        b_vld;
  logic [31:0] b_sq [cdpg_pkg::NCORNER][cdpg_pkg::NAXIS];

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else     b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cdpg_pkg::NCORNER; i++) begin
      for (int a = 0; a < cdpg_pkg::NAXIS; a++) begin
        if (cdpg_pkg::CORNER_POS[i][a])
          b_sq[i][a] <= 32'(u_hi[a]) * 32'(u_hi[a]);
        else
          b_sq[i][a] <= 32'(u_lo[a]) * 32'(u_lo[a]);
      end
    end
  end

  // fade set follows the item down to the fade stages
  cdpg_pkg::fade_set_t fdl [cdpg_pkg::FADE_DLY+1];

  always_ff @(posedge clk) begin
    fdl[0] <= fade_now;
    for (int k = 1; k <= cdpg_pkg::FADE_DLY; k++) fdl[k] <= fdl[k-1];
  end

  logic        c_vld;
  logic [31:0] c_d2 [cdpg_pkg::NCORNER];

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else     c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cdpg_pkg::NCORNER; i++)
      c_d2[i] <= b_sq[i][0] + b_sq[i][1] + b_sq[i][2];
  end

  // ---------------- distance, denominator, raw gain ----------------
  logic                        s1_vld;
  logic [cdpg_pkg::ROOT_W-1:0] s1_root [cdpg_pkg::NCORNER];
  logic                        r_vld;
  logic [cdpg_pkg::RGAIN_W-1:0] r_gain [cdpg_pkg::NCORNER];
  logic [cdpg_pkg::DEN_W-1:0]  e_den [cdpg_pkg::NCORNER];
  logic                        e_vld;

  for (genvar i = 0; i < cdpg_pkg::NCORNER; i++) begin : g_corner
    if (i == 0) begin : g_lead
      cdpg_sqrt u_dist (
        .clk      (clk),
        .rst      (rst),
        .in_vld   (c_vld),
        .in_val   ({32'd0, c_d2[i]}),
        .out_vld  (s1_vld),
        .out_root (s1_root[i])
      );
      cdpg_recip u_recip (
        .clk     (clk),
        .rst     (rst),
        .in_vld  (e_vld),
        .in_den  (e_den[i]),
        .out_vld (r_vld),
        .out_quo (r_gain[i])
      );
    end else begin : g_follow
      cdpg_sqrt u_dist (
        .clk      (clk),
        .rst      (rst),
        .in_vld   (c_vld),
        .in_val   ({32'd0, c_d2[i]}),
        .out_vld  (),
        .out_root (s1_root[i])
      );
      cdpg_recip u_recip (
        .clk     (clk),
        .rst     (rst),
        .in_vld  (e_vld),
        .in_den  (e_den[i]),
        .out_vld (),
        .out_quo (r_gain[i])
      );
    end
  end

  logic                        d_vld;
  logic [cdpg_pkg::DIST_W-1:0] d_d  [cdpg_pkg::NCORNER];
  logic [31:0]                 d_dd [cdpg_pkg::NCORNER];
  logic [cdpg_pkg::DIST_W-1:0] d_fl [cdpg_pkg::NCORNER];

  // distance floor of 0.001
  always_comb begin
    for (int i = 0; i < cdpg_pkg::NCORNER; i++) begin
      if (s1_root[i][cdpg_pkg::DIST_W-1:0] < cdpg_pkg::DIST_FLOOR) d_fl[i] = cdpg_pkg::DIST_FLOOR;
      else d_fl[i] = s1_root[i][cdpg_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else begin
      d_vld <= s1_vld;
      e_vld <= d_vld;
    end
  end

  // den = 2^28 + d*2^14 + 2*d^2, Q.28
  always_ff @(posedge clk) begin
    for (int i = 0; i < cdpg_pkg::NCORNER; i++) begin
      d_d[i]  <= d_fl[i];
      d_dd[i] <= 32'(d_fl[i]) * 32'(d_fl[i]);
      e_den[i] <= cdpg_pkg::DEN_ONE + {4'd0, d_d[i], 14'd0} + {1'b0, d_dd[i], 1'b0};
    end
  end

  // ---------------- face fades, x then y then z ----------------
  logic                         f1_vld, f2_vld, f3_vld;
  logic [cdpg_pkg::RGAIN_W-1:0] f1_g [cdpg_pkg::NCORNER];
  logic [cdpg_pkg::RGAIN_W-1:0] f2_g [cdpg_pkg::NCORNER];
  logic [cdpg_pkg::RGAIN_W-1:0] f3_g [cdpg_pkg::NCORNER];
  cdpg_pkg::fade_set_t          f1_fade, f2_fade;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
    end else begin
      f1_vld <= r_vld;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
    end
  end

  always_ff @(posedge clk) begin
    f1_fade <= fdl[cdpg_pkg::FADE_DLY];
    f2_fade <= f1_fade;
    for (int i = 0; i < cdpg_pkg::NCORNER; i++) begin
      f1_g[i] <= fade_mul(r_gain[i], fade_pick(fdl[cdpg_pkg::FADE_DLY], 3'(i), 2'd0));
      f2_g[i] <= fade_mul(f1_g[i], fade_pick(f1_fade, 3'(i), 2'd1));
      f3_g[i] <= fade_mul(f2_g[i], fade_pick(f2_fade, 3'(i), 2'd2));
    end
  end

  // ---------------- sum of squares: square, then a registered adder tree ----------------
  logic                         g_vld, h1_vld, h2_vld, h3_vld;
  logic [59:0]                  g_sq [cdpg_pkg::NCORNER];
  logic [60:0]                  h1_s [4];
  logic [61:0]                  h2_s [2];
  logic [62:0]                  h3_s;
  logic [cdpg_pkg::RGAIN_W-1:0] g_g  [cdpg_pkg::NCORNER];
  logic [cdpg_pkg::RGAIN_W-1:0] h1_g [cdpg_pkg::NCORNER];
  logic [cdpg_pkg::RGAIN_W-1:0] h2_g [cdpg_pkg::NCORNER];
  logic [cdpg_pkg::RGAIN_W-1:0] h3_g [cdpg_pkg::NCORNER];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld  <= 1'b0;
      h1_vld <= 1'b0;
      h2_vld <= 1'b0;
      h3_vld <= 1'b0;
    end else begin
      g_vld  <= f3_vld;
      h1_vld <= g_vld;
      h2_vld <= h1_vld;
      h3_vld <= h2_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cdpg_pkg::NCORNER; i++) begin
      g_sq[i] <= 60'(f3_g[i]) * 60'(f3_g[i]);
      g_g[i]  <= f3_g[i];
      h1_g[i] <= g_g[i];
      h2_g[i] <= h1_g[i];
      h3_g[i] <= h2_g[i];
    end
    for (int j = 0; j < 4; j++) h1_s[j] <= 61'(g_sq[2*j]) + 61'(g_sq[2*j+1]);
    for (int j = 0; j < 2; j++) h2_s[j] <= 62'(h1_s[2*j]) + 62'(h1_s[2*j+1]);
    h3_s <= 63'(h2_s[0]) + 63'(h2_s[1]);
  end

  // ---------------- norm root, then normalize ----------------
  logic                        s2_vld;
  logic [cdpg_pkg::ROOT_W-1:0] s2_root;

  cdpg_sqrt u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (h3_vld),
    .in_val   ({1'b0, h3_s}),
    .out_vld  (s2_vld),
    .out_root (s2_root)
  );

  // raw gains wait for the norm
  logic [cdpg_pkg::RGAIN_W-1:0] gdl [cdpg_pkg::SQRT_STEPS][cdpg_pkg::NCORNER];

  always_ff @(posedge clk) begin
    for (int i = 0; i < cdpg_pkg::NCORNER; i++) begin
      gdl[0][i] <= h3_g[i];
      for (int k = 1; k < cdpg_pkg::SQRT_STEPS; k++) gdl[k][i] <= gdl[k-1][i];
    end
  end

  logic                        n_vld;
  logic [cdpg_pkg::GAIN_W-1:0] n_gain [cdpg_pkg::NCORNER];

  for (genvar i = 0; i < cdpg_pkg::NCORNER; i++) begin : g_norm
    if (i == 0) begin : g_lead
      cdpg_ndiv u_div (
        .clk      (clk),
        .rst      (rst),
        .in_vld   (s2_vld),
        .in_gain  (gdl[cdpg_pkg::SQRT_STEPS-1][i]),
        .in_root  (s2_root),
        .out_vld  (n_vld),
        .out_gain (n_gain[i])
      );
    end else begin : g_follow
      cdpg_ndiv u_div (
        .clk      (clk),
        .rst      (rst),
        .in_vld   (s2_vld),
        .in_gain  (gdl[cdpg_pkg::SQRT_STEPS-1][i]),
        .in_root  (s2_root),
        .out_vld  (),
        .out_gain (n_gain[i])
      );
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= n_vld;
  end

  always_ff @(posedge clk) begin
    gain_0 <= n_gain[0];
    gain_1 <= n_gain[1];
    gain_2 <= n_gain[2];
    gain_3 <= n_gain[3];
    gain_4 <= n_gain[4];
    gain_5 <= n_gain[5];
    gain_6 <= n_gain[6];
    gain_7 <= n_gain[7];
  end

endmodule

/* design/cdpg_check.sv */
// Port-level checks for the cube panner, bound to the top level.
module cdpg_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [cdpg_pkg::GAIN_W-1:0] gain_0,
  input logic [cdpg_pkg::GAIN_W-1:0] gain_1,
  input logic [cdpg_pkg::GAIN_W-1:0] gain_2,
  input logic [cdpg_pkg::GAIN_W-1:0] gain_3,
  input logic [cdpg_pkg::GAIN_W-1:0] gain_4,
  input logic [cdpg_pkg::GAIN_W-1:0] gain_5,
  input logic [cdpg_pkg::GAIN_W-1:0] gain_6,
  input logic [cdpg_pkg::GAIN_W-1:0] gain_7
);

  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(cdpg_pkg::OUT_LATENCY) done)
    else $error("result missing at fixed latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, cdpg_pkg::OUT_LATENCY))
    else $error("result without a matching input transfer");

  a_some_gain: assert property (@(posedge clk) disable iff (rst)
    done |-> ((gain_0 | gain_1 | gain_2 | gain_3 | gain_4 | gain_5 | gain_6 | gain_7) != '0))
    else $error("all gains zero");

endmodule

bind cube_distance_panning_gains cdpg_check u_cdpg_check (.*);
